// ===== hw/rtl/cfr_pkg.sv =====
// Shared types, codes and constants of the car-following route step block.
package cfr_pkg;

    localparam int ROUTE_DEPTH_DEF = 256;

    localparam int SPEED_W = 16;
    localparam int DIST_W  = 24;
    localparam int TIME_W  = 16;
    localparam int IDX_W   = 9;
    localparam int PROG_W  = 16;
    localparam int SLOT_W  = 8;
    localparam int OP_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int QUOT_W  = 22;
    localparam int CNT_W   = 5;

    localparam logic [QUOT_W-1:0] RATIO_CAP = 22'h3F_FFFF;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD    = 2'd0,
        OP_RESTART = 2'd1,
        OP_STEP    = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_GAP       = 3'd0,
        REG_REACTION_TIME = 3'd1,
        REG_MAX_ACCEL     = 3'd2,
        REG_BRAKING_COEFF = 3'd3,
        REG_SAMPLE_TIME   = 3'd4,
        REG_ROUTE_LENGTH  = 3'd5
    } t_reg;

    typedef enum logic [4:0] {
        ST_IDLE, ST_RDLIM, ST_MUL1, ST_MUL2, ST_MUL3, ST_SUM, ST_DES,
        ST_QSTART, ST_QWAIT, ST_RSTART, ST_RWAIT,
        ST_MQ2, ST_MQ4, ST_MR2, ST_B, ST_MACC, ST_ACC, ST_ADV, ST_ADV2,
        ST_REM, ST_REM2, ST_WALK, ST_WADD, ST_PSTART, ST_PWAIT, ST_EMIT
    } t_state;

    typedef struct packed {
        logic              start;
        logic [DIST_W-1:0] den;
        logic [DIST_W-1:0] rem0;
        logic [QUOT_W-1:0] low;
        logic [CNT_W-1:0]  count;
    } t_div_req;

endpackage

// ===== hw/rtl/cfr_if.sv =====
// Handshake channels of the car-following route step block.
interface cfr_in_if;
    import cfr_pkg::*;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [SLOT_W-1:0]   segment_slot;
    logic [DIST_W-1:0]   segment_length;
    logic [SPEED_W-1:0]  segment_speed_limit;
    logic [DIST_W-1:0]   gap_to_leader;
    logic [SPEED_W-1:0]  leader_speed;
    modport source (output valid, operation, segment_slot, segment_length,
                    segment_speed_limit, gap_to_leader, leader_speed, input ready);
    modport sink   (input valid, operation, segment_slot, segment_length,
                    segment_speed_limit, gap_to_leader, leader_speed, output ready);
endinterface

interface cfr_out_if;
    import cfr_pkg::*;
    logic                valid;
    logic                ready;
    logic [SPEED_W-1:0]  car_speed_out;
    logic [IDX_W-1:0]    segment_index_out;
    logic [PROG_W-1:0]   progress_out;
    logic                on_map;
    modport source (output valid, car_speed_out, segment_index_out, progress_out, on_map,
                    input ready);
    modport sink   (input valid, car_speed_out, segment_index_out, progress_out, on_map,
                    output ready);
endinterface

interface cfr_cfg_if;
    import cfr_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/cfr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hw/rtl/cfr_div.sv =====
// Restoring divider, one quotient bit per cycle.
module cfr_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cfr_pkg::t_div_req           i_req,
    output logic                        o_done,
    output logic [cfr_pkg::QUOT_W-1:0]  o_quot
);
    import cfr_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIST_W-1:0] r_rem;
    logic [DIST_W-1:0] r_den;
    logic [QUOT_W-1:0] r_low;
    logic [QUOT_W-1:0] r_quot;
    logic [DIST_W:0]   w_trial;
    logic [DIST_W:0]   w_diff;
    logic              w_ge;

    assign w_trial = {r_rem, r_low[QUOT_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_busy <= (r_cnt != CNT_W'(1));
            r_done <= (r_cnt == CNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_cnt  <= i_req.count;
            r_rem  <= i_req.rem0;
            r_den  <= i_req.den;
            r_low  <= i_req.low;
            r_quot <= '0;
        end else if (r_busy) begin
            r_cnt  <= r_cnt - CNT_W'(1);
            r_rem  <= w_ge ? w_diff[DIST_W-1:0] : w_trial[DIST_W-1:0];
            r_low  <= {r_low[QUOT_W-2:0], 1'b0};
            r_quot <= {r_quot[QUOT_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

// ===== hw/rtl/car_following_route_step_core.sv =====
// Top level: intelligent-driver-model car following over a stored route.
//
//  channel | dir | payload                                           | transfer when
//  i_in    | in  | operation, slot, length, limit, gap, leader speed | valid && ready
//  o_out   | out | car speed, segment index, progress, on_map        | valid && ready
//  i_cfg   | in  | register index, write data                        | valid && ready
//
//  Load, restart and no-op items go from idle straight to the emit state. A step runs the
//  sequencer from its transfer to its emit state, plus a walk and a walk-add state per
//  segment boundary crossed; the two ratio divisions (one quotient bit per cycle in the
//  shared divider) and the progress division dominate.
//  A saturated ratio skips its division; a zero gap skips the whole acceleration path.
//  Reset (synchronous, active low) zeroes the car and loads register defaults; the
//  route stores hold garbage until loaded. A stalled output holds the sequencer at its
//  last state; the next item is taken while the result waits in the output register.
module car_following_route_step_core #(
    parameter int ROUTE_DEPTH = cfr_pkg::ROUTE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cfr_in_if.sink      i_in,
    cfr_out_if.source   o_out,
    cfr_cfg_if.sink     i_cfg
);
    import cfr_pkg::*;

    localparam int AW = $clog2(ROUTE_DEPTH);
    localparam int RW = DIST_W + SPEED_W;
    localparam logic signed [41:0] B_FLOOR = -42'sh4_0000_0000;

    // configuration
    logic [DIST_W-1:0]  r_min_gap;
    logic [TIME_W-1:0]  r_rt;
    logic [SPEED_W-1:0] r_ma;
    logic [SPEED_W-1:0] r_bc;
    logic [TIME_W-1:0]  r_st;
    logic [IDX_W-1:0]   r_route_length;

    // car state and sequencer
    t_state             r_state, n_state;
    logic [SPEED_W-1:0] r_speed;
    logic [IDX_W-1:0]   r_seg;
    logic [PROG_W-1:0]  r_prog;

    // working registers
    logic [DIST_W-1:0]  r_gap;
    logic [SPEED_W-1:0] r_lead;
    logic [SPEED_W-1:0] r_limit;
    logic signed [65:0] r_prod;
    logic signed [50:0] r_s;
    logic [33:0]        r_desired;
    logic [QUOT_W-1:0]  r_q;
    logic [QUOT_W-1:0]  r_r;
    logic signed [41:0] r_b;
    logic signed [17:0] r_acc;
    logic [20:0]        r_adv;
    logic [25:0]        r_rem;
    logic [DIST_W-1:0]  r_len;
    logic [IDX_W-1:0]   r_idx;

    // output register
    logic               r_out_valid;
    logic [SPEED_W-1:0] r_out_speed;
    logic [IDX_W-1:0]   r_out_seg;
    logic [PROG_W-1:0]  r_out_prog;
    logic               r_out_on_map;

    logic               w_accept;
    logic               w_emit;
    logic [IDX_W-1:0]   w_n;
    logic [IDX_W-1:0]   w_seg_sel;
    logic [IDX_W-1:0]   w_idx_nx;
    logic               w_we;
    logic [AW-1:0]      w_raddr;
    logic [RW-1:0]      w_rd;
    logic [DIST_W-1:0]  w_rd_len;
    logic [SPEED_W-1:0] w_rd_lim;
    logic signed [36:0] w_mul_a;
    logic signed [28:0] w_mul_b;
    logic signed [65:0] w_mul_p;
    logic [16:0]        w_vdiff;
    logic [16:0]        w_frac;
    logic signed [35:0] w_bcl;
    logic signed [47:0] w_acc_raw;
    logic signed [47:0] w_negv;
    logic signed [18:0] w_twov;
    logic signed [18:0] w_nv;
    logic               w_q_cap;
    logic               w_r_cap;
    logic               w_walk_on;
    logic [25:0]        w_local;
    t_div_req           w_div_req;
    logic               w_div_done;
    logic [QUOT_W-1:0]  w_div_quot;

    assign w_accept  = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_emit    = (r_state == ST_EMIT) && (!r_out_valid || o_out.ready);

    // effective route length: zero counts as one, clip at the store depth
    always_comb begin
        if (r_route_length == '0) begin
            w_n = IDX_W'(1);
        end else if (32'(r_route_length) > ROUTE_DEPTH) begin
            w_n = IDX_W'(ROUTE_DEPTH);
        end else begin
            w_n = r_route_length;
        end
    end

    assign w_seg_sel = (r_seg < w_n) ? r_seg : (w_n - IDX_W'(1));
    assign w_idx_nx  = r_idx + IDX_W'(1);

    // route store: {length, speed limit}
    assign w_we = w_accept && (t_op'(i_in.operation) == OP_LOAD)
                  && (32'(i_in.segment_slot) < ROUTE_DEPTH);

    always_comb begin
        unique case (r_state)
            ST_RDLIM: w_raddr = AW'(w_seg_sel);
            ST_ADV2:  w_raddr = AW'(r_seg);
            ST_WALK:  w_raddr = AW'(w_idx_nx);
            default:  w_raddr = '0;
        endcase
    end

    cfr_ram #(.WIDTH(RW), .DEPTH(ROUTE_DEPTH)) u_route (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(i_in.segment_slot)),
        .i_wdata ({i_in.segment_length, i_in.segment_speed_limit}),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    assign w_rd_len = w_rd[RW-1:SPEED_W];
    assign w_rd_lim = w_rd[SPEED_W-1:0];

    // shared multiplier, product registered in r_prod
    assign w_vdiff = {1'b0, r_speed} - {1'b0, r_lead};
    assign w_frac  = 17'h1_0000 - {1'b0, r_prog};
    assign w_bcl   = (r_b < B_FLOOR) ? B_FLOOR[35:0] : r_b[35:0];
    assign w_twov  = $signed({2'b0, r_speed, 1'b0}) + $signed({r_acc[17], r_acc});
    assign w_nv    = $signed({3'b0, r_speed}) + $signed({r_acc[17], r_acc});

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            ST_MUL1: begin
                w_mul_a = $signed({21'b0, r_speed});
                w_mul_b = $signed({13'b0, r_rt});
            end
            ST_MUL2: begin
                w_mul_a = $signed({21'b0, r_speed});
                w_mul_b = $signed({{12{w_vdiff[16]}}, w_vdiff});
            end
            ST_MUL3: begin
                w_mul_a = r_prod[36:0];
                w_mul_b = $signed({13'b0, r_bc});
            end
            ST_MQ2: begin
                w_mul_a = $signed({15'b0, r_q});
                w_mul_b = $signed({7'b0, r_q});
            end
            ST_MQ4: begin
                w_mul_a = $signed({9'b0, r_prod[43:16]});
                w_mul_b = $signed({1'b0, r_prod[43:16]});
            end
            ST_MR2: begin
                w_mul_a = $signed({15'b0, r_r});
                w_mul_b = $signed({7'b0, r_r});
            end
            ST_MACC: begin
                w_mul_a = $signed({w_bcl[35], w_bcl});
                w_mul_b = $signed({13'b0, r_ma});
            end
            ST_ADV: begin
                w_mul_a = $signed({{18{w_twov[18]}}, w_twov});
                w_mul_b = $signed({13'b0, r_st});
            end
            ST_REM: begin
                w_mul_a = $signed({20'b0, w_frac});
                w_mul_b = $signed({5'b0, w_rd_len});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_mul_p = w_mul_a * w_mul_b;

    assign w_acc_raw = $signed(r_prod[65:18]);
    assign w_negv    = -$signed({32'b0, r_speed});

    // a ratio saturates when its top quotient bits would already overflow
    assign w_q_cap   = ({6'b0, r_speed[15:6]} >= r_limit);
    assign w_r_cap   = (r_desired[33:6] >= {4'b0, r_gap});
    assign w_walk_on = (r_rem <= {5'b0, r_adv});
    assign w_local   = {5'b0, r_adv} + {2'b0, r_len} - r_rem;

    always_comb begin
        w_div_req = '0;
        unique case (r_state)
            ST_QSTART: begin
                w_div_req.start = !w_q_cap;
                w_div_req.den   = {8'b0, r_limit};
                w_div_req.rem0  = {14'b0, r_speed[15:6]};
                w_div_req.low   = {r_speed[5:0], 16'b0};
                w_div_req.count = CNT_W'(QUOT_W);
            end
            ST_RSTART: begin
                w_div_req.start = !w_r_cap;
                w_div_req.den   = r_gap;
                w_div_req.rem0  = r_desired[29:6];
                w_div_req.low   = {r_desired[5:0], 16'b0};
                w_div_req.count = CNT_W'(QUOT_W);
            end
            ST_PSTART: begin
                w_div_req.start = 1'b1;
                w_div_req.den   = r_len;
                w_div_req.rem0  = w_local[DIST_W-1:0];
                w_div_req.low   = '0;
                w_div_req.count = CNT_W'(PROG_W);
            end
            default: w_div_req = '0;
        endcase
    end

    cfr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (t_op'(i_in.operation) == OP_STEP) ? ST_RDLIM : ST_EMIT;
                end
            end
            ST_RDLIM:  n_state = (r_gap == '0) ? ST_ADV : ST_MUL1;
            ST_MUL1:   n_state = ST_MUL2;
            ST_MUL2:   n_state = ST_MUL3;
            ST_MUL3:   n_state = ST_SUM;
            ST_SUM:    n_state = ST_DES;
            ST_DES:    n_state = ST_QSTART;
            ST_QSTART: n_state = w_q_cap ? ST_RSTART : ST_QWAIT;
            ST_QWAIT:  n_state = w_div_done ? ST_RSTART : ST_QWAIT;
            ST_RSTART: n_state = w_r_cap ? ST_MQ2 : ST_RWAIT;
            ST_RWAIT:  n_state = w_div_done ? ST_MQ2 : ST_RWAIT;
            ST_MQ2:    n_state = ST_MQ4;
            ST_MQ4:    n_state = ST_MR2;
            ST_MR2:    n_state = ST_B;
            ST_B:      n_state = ST_MACC;
            ST_MACC:   n_state = ST_ACC;
            ST_ACC:    n_state = ST_ADV;
            ST_ADV:    n_state = ST_ADV2;
            ST_ADV2:   n_state = (r_seg < w_n) ? ST_REM : ST_EMIT;
            ST_REM:    n_state = ST_REM2;
            ST_REM2:   n_state = ST_WALK;
            ST_WALK: begin
                if (w_walk_on) begin
                    n_state = (w_idx_nx < w_n) ? ST_WADD : ST_EMIT;
                end else begin
                    n_state = ST_PSTART;
                end
            end
            ST_WADD:   n_state = ST_WALK;
            ST_PSTART: n_state = ST_PWAIT;
            ST_PWAIT:  n_state = w_div_done ? ST_EMIT : ST_PWAIT;
            ST_EMIT:   n_state = w_emit ? ST_IDLE : ST_EMIT;
            default:   n_state = ST_IDLE;
        endcase
    end

    // configuration registers and car state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_gap      <= DIST_W'(512);
            r_rt           <= TIME_W'(6144);
            r_ma           <= SPEED_W'(1024);
            r_bc           <= SPEED_W'(512);
            r_st           <= TIME_W'(410);
            r_route_length <= IDX_W'(1);
            r_speed        <= '0;
            r_seg          <= '0;
            r_prog         <= '0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (t_reg'(i_cfg.index))
                    REG_MIN_GAP:       r_min_gap      <= i_cfg.data;
                    REG_REACTION_TIME: r_rt           <= i_cfg.data[TIME_W-1:0];
                    REG_MAX_ACCEL:     r_ma           <= i_cfg.data[SPEED_W-1:0];
                    REG_BRAKING_COEFF: r_bc           <= i_cfg.data[SPEED_W-1:0];
                    REG_SAMPLE_TIME:   r_st           <= i_cfg.data[TIME_W-1:0];
                    REG_ROUTE_LENGTH:  r_route_length <= i_cfg.data[IDX_W-1:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept && (t_op'(i_in.operation) == OP_RESTART)) begin
                        r_speed <= '0;
                        r_seg   <= '0;
                        r_prog  <= '0;
                    end
                end
                ST_ADV: begin
                    // add the clamped acceleration, saturate at the top of the format
                    r_speed <= (w_nv > 19'sd65535) ? {SPEED_W{1'b1}} : w_nv[SPEED_W-1:0];
                end
                ST_ADV2: begin
                    if (r_seg >= w_n) begin
                        r_seg <= w_n;
                    end
                end
                ST_WALK: begin
                    // ran past the route end: park at L, keep progress
                    if (w_walk_on && (w_idx_nx >= w_n)) begin
                        r_seg <= w_n;
                    end
                end
                ST_PWAIT: begin
                    if (w_div_done) begin
                        r_seg  <= r_idx;
                        r_prog <= w_div_quot[PROG_W-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath working registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    r_gap  <= i_in.gap_to_leader;
                    r_lead <= i_in.leader_speed;
                end
            end
            ST_RDLIM: begin
                if (r_gap == '0) begin
                    r_acc <= -$signed({2'b0, r_speed});
                end
            end
            ST_MUL1: begin
                r_limit <= w_rd_lim;
                r_prod  <= w_mul_p;
            end
            ST_MUL2: begin
                r_s    <= {r_prod[44:0], 6'b0};
                r_prod <= w_mul_p;
            end
            ST_MUL3: r_prod <= w_mul_p;
            ST_SUM:  r_s <= r_s + r_prod[50:0];
            ST_DES: begin
                r_desired <= {10'b0, r_min_gap} + ((r_s > 51'sd0) ? {1'b0, r_s[50:18]} : 34'd0);
            end
            ST_QSTART: begin
                if (w_q_cap) begin
                    r_q <= RATIO_CAP;
                end
            end
            ST_QWAIT: begin
                if (w_div_done) begin
                    r_q <= w_div_quot;
                end
            end
            ST_RSTART: begin
                if (w_r_cap) begin
                    r_r <= RATIO_CAP;
                end
            end
            ST_RWAIT: begin
                if (w_div_done) begin
                    r_r <= w_div_quot;
                end
            end
            ST_MQ2: r_prod <= w_mul_p;
            ST_MQ4: r_prod <= w_mul_p;
            ST_MR2: begin
                r_b    <= 42'sd65536 - $signed({2'b0, r_prod[55:16]});
                r_prod <= w_mul_p;
            end
            ST_B:    r_b <= r_b - $signed({14'b0, r_prod[43:16]});
            ST_MACC: r_prod <= w_mul_p;
            ST_ACC: begin
                // floor shift, then never brake below standstill
                r_acc <= (w_acc_raw < w_negv) ? w_negv[17:0] : w_acc_raw[17:0];
            end
            ST_ADV:  r_prod <= w_mul_p;
            ST_ADV2: begin
                r_adv <= r_prod[33:13];
                r_idx <= r_seg;
            end
            ST_REM: begin
                r_len  <= w_rd_len;
                r_prod <= w_mul_p;
            end
            ST_REM2: r_rem <= {1'b0, r_prod[40:16]};
            ST_WALK: begin
                if (w_walk_on && (w_idx_nx < w_n)) begin
                    r_idx <= w_idx_nx;
                end
            end
            ST_WADD: begin
                r_len <= w_rd_len;
                r_rem <= r_rem + {2'b0, w_rd_len};
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_speed  <= r_speed;
            r_out_seg    <= r_seg;
            r_out_prog   <= r_prog;
            r_out_on_map <= (r_seg < w_n);
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.car_speed_out     = r_out_speed;
    assign o_out.segment_index_out = r_out_seg;
    assign o_out.progress_out      = r_out_prog;
    assign o_out.on_map            = r_out_on_map;

    // the divider reports completion only to a state waiting on it
    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_QWAIT || r_state == ST_RWAIT || r_state == ST_PWAIT))
        else $error("divider finished outside a wait state");

    // the walk never looks at a segment beyond the route
    a_walk_in_route: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK || r_state == ST_PSTART) |-> (r_idx < w_n))
        else $error("walk index beyond route length");

    // a new result appears only from the emit state
    a_emit_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_EMIT))
        else $error("result raised outside emit");

    // a progress update always lands on a segment inside the route
    a_seg_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && $past(r_state) == ST_PWAIT) |-> (r_seg < w_n))
        else $error("progress written for an off-route segment");
endmodule
